### src/qrv_pkg.sv
// Shared constants for the quaternion vector rotation pipeline.
package qrv_pkg;

  localparam int NUM_AXES = 3;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

endpackage

### src/qrv_arith.sv
// Product and sum stages that form the rotation numerators and the squared norm.
module qrv_arith
  import qrv_pkg::*;
#(
  parameter int CW   = 16,
  parameter int NRMW = 2 * CW + 1,
  parameter int NW   = 3 * CW + 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [CW-1:0]                q_w,
  input  logic signed [CW-1:0]                q_x,
  input  logic signed [CW-1:0]                q_y,
  input  logic signed [CW-1:0]                q_z,
  input  logic signed [CW-1:0]                vec_x,
  input  logic signed [CW-1:0]                vec_y,
  input  logic signed [CW-1:0]                vec_z,
  output logic                                out_valid,
  output logic [NUM_AXES-1:0][NW-1:0]         out_mag,
  output logic [NUM_AXES-1:0]                 out_neg,
  output logic [NRMW-1:0]                     out_norm,
  output logic                                out_zero
);

  localparam int PW = 2 * CW;
  localparam int SW = 2 * CW + 2;
  localparam int MW = SW + CW + 1;

  logic [3:0] vld_r;

  // Stage 1: squares of the quaternion components and products of q_x..q_z with the vector.
  logic signed [PW-1:0] sq_r  [4];
  logic signed [PW-1:0] dot_r [NUM_AXES];
  logic signed [PW-1:0] pa_r  [NUM_AXES];
  logic signed [PW-1:0] pb_r  [NUM_AXES];
  logic signed [CW-1:0] w1_r;
  logic signed [CW-1:0] u1_r  [NUM_AXES];
  logic signed [CW-1:0] v1_r  [NUM_AXES];

  // Stage 2: norm, scalar terms and cross product.
  logic signed [SW-1:0] norm2_r;
  logic signed [SW-1:0] s2_r;
  logic signed [SW-1:0] d2_r;
  logic signed [SW-1:0] c2_r  [NUM_AXES];
  logic signed [CW-1:0] w2_r;
  logic signed [CW-1:0] u2_r  [NUM_AXES];
  logic signed [CW-1:0] v2_r  [NUM_AXES];

  // Stage 3: second products.
  logic signed [MW-1:0] sv3_r [NUM_AXES];
  logic signed [MW-1:0] du3_r [NUM_AXES];
  logic signed [MW-1:0] wc3_r [NUM_AXES];
  logic signed [SW-1:0] norm3_r;

  // Stage 4: numerator split into sign and magnitude.
  logic [NUM_AXES-1:0][NW-1:0] mag4_r;
  logic [NUM_AXES-1:0]         neg4_r;
  logic [NRMW-1:0]             norm4_r;
  logic                        zero4_r;

  logic signed [NW-1:0] num [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= PW'(q_w * q_w);
      sq_r[1] <= PW'(q_x * q_x);
      sq_r[2] <= PW'(q_y * q_y);
      sq_r[3] <= PW'(q_z * q_z);
      dot_r[AXIS_X] <= PW'(q_x * vec_x);
      dot_r[AXIS_Y] <= PW'(q_y * vec_y);
      dot_r[AXIS_Z] <= PW'(q_z * vec_z);
      pa_r[AXIS_X]  <= PW'(q_y * vec_z);
      pb_r[AXIS_X]  <= PW'(q_z * vec_y);
      pa_r[AXIS_Y]  <= PW'(q_z * vec_x);
      pb_r[AXIS_Y]  <= PW'(q_x * vec_z);
      pa_r[AXIS_Z]  <= PW'(q_x * vec_y);
      pb_r[AXIS_Z]  <= PW'(q_y * vec_x);
      w1_r <= q_w;
      u1_r[AXIS_X] <= q_x;
      u1_r[AXIS_Y] <= q_y;
      u1_r[AXIS_Z] <= q_z;
      v1_r[AXIS_X] <= vec_x;
      v1_r[AXIS_Y] <= vec_y;
      v1_r[AXIS_Z] <= vec_z;

      norm2_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]);
      s2_r    <= SW'(sq_r[0]) - SW'(sq_r[1]) - SW'(sq_r[2]) - SW'(sq_r[3]);
      d2_r    <= SW'(dot_r[0]) + SW'(dot_r[1]) + SW'(dot_r[2]);
      for (int i = 0; i < NUM_AXES; i++) begin
        c2_r[i] <= SW'(pa_r[i]) - SW'(pb_r[i]);
        u2_r[i] <= u1_r[i];
        v2_r[i] <= v1_r[i];
      end
      w2_r <= w1_r;

      for (int i = 0; i < NUM_AXES; i++) begin
        sv3_r[i] <= MW'(s2_r) * MW'(v2_r[i]);
        du3_r[i] <= MW'(d2_r) * MW'(u2_r[i]);
        wc3_r[i] <= MW'(w2_r) * MW'(c2_r[i]);
      end
      norm3_r <= norm2_r;

      for (int i = 0; i < NUM_AXES; i++) begin
        neg4_r[i] <= num[i][NW-1];
        mag4_r[i] <= num[i][NW-1] ? NW'(-num[i]) : NW'(num[i]);
      end
      norm4_r <= norm3_r[NRMW-1:0];
      zero4_r <= (norm3_r == '0);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      num[i] = NW'(sv3_r[i]) + (NW'(du3_r[i]) <<< 1) + (NW'(wc3_r[i]) <<< 1);
    end
  end

  assign out_valid = vld_r[3];
  assign out_mag   = mag4_r;
  assign out_neg   = neg4_r;
  assign out_norm  = norm4_r;
  assign out_zero  = zero4_r;

endmodule

### src/qrv_div.sv
// Pipelined restoring divider, one quotient bit per stage, for all three axes.
module qrv_div
  import qrv_pkg::*;
#(
  parameter int CW   = 16,
  parameter int NRMW = 2 * CW + 1,
  parameter int NW   = 3 * CW + 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [NUM_AXES-1:0][NW-1:0]  in_mag,
  input  logic [NUM_AXES-1:0]          in_neg,
  input  logic [NRMW-1:0]              in_norm,
  input  logic                         in_zero,
  output logic                         out_valid,
  output logic [NUM_AXES-1:0][CW-1:0]  out_quot,
  output logic [NUM_AXES-1:0]          out_ovf,
  output logic [NUM_AXES-1:0]          out_neg,
  output logic                         out_zero
);

  localparam int NS = CW + 1;
  localparam int XW = NW + CW + 1;

  logic [NS-1:0]                        vld_r;
  logic [NS-1:0][NUM_AXES-1:0][NW-1:0]  rem_r;
  logic [NS-1:0][NUM_AXES-1:0][CW-1:0]  quot_r;
  logic [NS-1:0][NUM_AXES-1:0]          ovf_r;
  logic [NS-1:0][NUM_AXES-1:0]          neg_r;
  logic [NS-1:0][NRMW-1:0]              norm_r;
  logic [NS-1:0]                        zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // The first stage only checks whether the quotient would need more than CW bits.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        rem_r[0][i]  <= in_mag[i];
        quot_r[0][i] <= '0;
        ovf_r[0][i]  <= (XW'(in_mag[i]) >= (XW'(in_norm) << CW));
      end
      neg_r[0]  <= in_neg;
      norm_r[0] <= in_norm;
      zero_r[0] <= in_zero;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam int BIT = CW - s;
    logic [NUM_AXES-1:0][NW-1:0] rem_nxt;
    logic [NUM_AXES-1:0][CW-1:0] quot_nxt;
    logic [XW-1:0]               sub;

    always_comb begin
      sub = XW'(norm_r[s-1]) << BIT;
      for (int i = 0; i < NUM_AXES; i++) begin
        rem_nxt[i]  = rem_r[s-1][i];
        quot_nxt[i] = quot_r[s-1][i];
        if (XW'(rem_r[s-1][i]) >= sub) begin
          rem_nxt[i]       = rem_r[s-1][i] - sub[NW-1:0];
          quot_nxt[i][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        quot_r[s] <= quot_nxt;
        ovf_r[s]  <= ovf_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        norm_r[s] <= norm_r[s-1];
        zero_r[s] <= zero_r[s-1];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_quot  = quot_r[NS-1];
  assign out_ovf   = ovf_r[NS-1];
  assign out_neg   = neg_r[NS-1];
  assign out_zero  = zero_r[NS-1];

endmodule

### src/quaternion_rotate_vector_core.sv
// Quaternion vector rotation core: rotates one vector per cycle, unless stalled by out_ready, by q*(0,v)*q^-1.
//
// The input channel carries a quaternion (q_w..q_z, signed Q2.14 at the default
// width) and an integer vector (vec_x..vec_z). A transfer happens when in_valid
// and in_ready are both high. The result channel returns rot_x..rot_z, truncated
// toward zero and saturated, with the saturated and zero_quaternion flags.
// The numerator is divided by the squared norm, so a non-unit quaternion
// does not scale the vector. An all-zero quaternion gives zero
// components with zero_quaternion set.
//
// From input transfer to out_valid an item passes four product and sum stages,
// COMPONENT_WIDTH + 1 divider stages (the first checks for overflow, each other
// yields one quotient bit) and the output register. Throughput is one item per
// cycle while results are drained. When the receiver holds out_ready low with
// a result waiting, the whole pipeline freezes and in_ready drops; nothing is
// lost or repeated. Synchronous reset clears all valid bits; payload registers
// are not reset.
module quaternion_rotate_vector_core
  import qrv_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] in_q_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_q_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_q_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_q_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COMPONENT_WIDTH-1:0] out_rot_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_rot_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_rot_z,
  output logic                              out_saturated,
  output logic                              out_zero_quaternion
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int NRMW = 2 * CW + 1;
  localparam int NW   = 3 * CW + 6;

  logic                        en;
  logic                        a_valid;
  logic [NUM_AXES-1:0][NW-1:0] a_mag;
  logic [NUM_AXES-1:0]         a_neg;
  logic [NRMW-1:0]             a_norm;
  logic                        a_zero;

  logic                        d_valid;
  logic [NUM_AXES-1:0][CW-1:0] d_quot;
  logic [NUM_AXES-1:0]         d_ovf;
  logic [NUM_AXES-1:0]         d_neg;
  logic                        d_zero;

  logic                        out_valid_r;
  logic [NUM_AXES-1:0][CW-1:0] rot_r;
  logic                        sat_r;
  logic                        zq_r;

  logic [NUM_AXES-1:0][CW-1:0] rot_nxt;
  logic [NUM_AXES-1:0]         sat_lane;

  // The pipeline advances whenever the output register is empty or being drained.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  qrv_arith #(.CW(CW), .NRMW(NRMW), .NW(NW)) u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .q_w      (in_q_w),
    .q_x      (in_q_x),
    .q_y      (in_q_y),
    .q_z      (in_q_z),
    .vec_x    (in_vec_x),
    .vec_y    (in_vec_y),
    .vec_z    (in_vec_z),
    .out_valid(a_valid),
    .out_mag  (a_mag),
    .out_neg  (a_neg),
    .out_norm (a_norm),
    .out_zero (a_zero)
  );

  qrv_div #(.CW(CW), .NRMW(NRMW), .NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (a_valid),
    .in_mag   (a_mag),
    .in_neg   (a_neg),
    .in_norm  (a_norm),
    .in_zero  (a_zero),
    .out_valid(d_valid),
    .out_quot (d_quot),
    .out_ovf  (d_ovf),
    .out_neg  (d_neg),
    .out_zero (d_zero)
  );

  // A negative result may reach the most negative code; a positive one stops one short.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (d_neg[i]) begin
        sat_lane[i] = d_ovf[i] || ({1'b0, d_quot[i]} > ((CW+1)'(1) << (CW - 1)));
      end else begin
        sat_lane[i] = d_ovf[i] || d_quot[i][CW-1];
      end
      if (d_zero) begin
        rot_nxt[i] = '0;
      end else if (sat_lane[i]) begin
        rot_nxt[i] = d_neg[i] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        rot_nxt[i] = d_neg[i] ? CW'(-d_quot[i]) : d_quot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
      sat_r <= !d_zero && (sat_lane != '0);
      zq_r  <= d_zero;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rot_x           = rot_r[AXIS_X];
  assign out_rot_y           = rot_r[AXIS_Y];
  assign out_rot_z           = rot_r[AXIS_Z];
  assign out_saturated       = sat_r;
  assign out_zero_quaternion = zq_r;

endmodule
